>>> rtl/core/ngram_lexicon_counter_assert.svh
// Assertion macros for the n-gram lexicon counter RTL.
`ifndef NGRAM_LEXICON_COUNTER_ASSERT_SVH
`define NGRAM_LEXICON_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NGL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngram lexicon counter assertion failed");

// Next-cycle implication, disabled during reset.
`define NGL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngram lexicon counter assertion failed");

`endif

>>> rtl/core/ngl_pkg.sv
// ---------------------------------------------------------------------------
// ngl_pkg
// Constants, types and helpers for the byte n-gram lexicon counter.
// ---------------------------------------------------------------------------
`default_nettype none

package ngl_pkg;

    localparam int MAX_GRAM    = 8;
    localparam int LEX_ENTRIES = 1024;
    localparam int COUNT_BITS  = 16;

    localparam int STORE_DEPTH = MAX_GRAM * LEX_ENTRIES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LEX_AW      = $clog2(LEX_ENTRIES);
    localparam int FILL_W      = LEX_AW + 1;
    localparam int LEN_IW      = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int GEN_W       = 16;
    localparam int TALLY_W     = GEN_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] REG_MIN_GRAM = 2'd0;
    localparam logic [1:0] REG_MAX_GRAM = 2'd1;
    localparam logic [1:0] REG_UPDATE   = 2'd2;

    typedef logic [STORE_AW-1:0] store_addr_t;

    typedef struct packed {
        logic                 rd_en;
        store_addr_t          addr;
        logic                 gram_we;
        logic [63:0]          gram_wdata;
        logic                 tally_we;
        logic [TALLY_W-1:0]   tally_wdata;
    } store_req_t;

    function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] value);
        logic [31:0] wide;
        wide = 32'(value);
        if (wide > 32'h0000_FFFF)
            return 16'hFFFF;
        return wide[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ngl_store.sv
// ---------------------------------------------------------------------------
// ngl_store
// Lexicon store: gram words and per-entry tallies (generation and count).
// ---------------------------------------------------------------------------
`default_nettype none

module ngl_store (
    input  wire logic                        clk,
    input  wire ngl_pkg::store_req_t         req,
    output logic [63:0]                      gram_rdata,
    output logic [ngl_pkg::TALLY_W-1:0]      tally_rdata
);
    import ngl_pkg::*;

    logic [63:0]        gram_mem  [STORE_DEPTH];
    logic [TALLY_W-1:0] tally_mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.gram_we)
        begin
            gram_mem[req.addr] <= req.gram_wdata;
        end
        if (req.rd_en)
        begin
            gram_rdata <= gram_mem[req.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.tally_we)
        begin
            tally_mem[req.addr] <= req.tally_wdata;
        end
        if (req.rd_en)
        begin
            tally_rdata <= tally_mem[req.addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ngram_lexicon_counter.sv
// ---------------------------------------------------------------------------
// ngram_lexicon_counter
// Byte n-gram counter with one lexicon per gram length and per-passage counts.
// ---------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_*      in         s_tvalid/s_tready   byte, passage index, first-byte flag
//  m_*      out        m_tvalid/m_tready   one gram report, tlast on last of byte
//  cfg_*    in         cfg_we              min_gram, max_gram, update_lexicon
//
// Each byte passes an accept and a prepare step, then, for every gram length
// reported, a check step, a search and compare per lexicon entry compared, and
// an emit step; the linear search in the single-ported store sets the pace.
// Reset needs no clearing pass; on a passage generation wrap, a pass over all
// 8192 store entries clears their generations before the byte is processed.
// A stalled result holds the sequencer in its emit step; no byte is taken
// until all reports of the current byte are in the output register.
`default_nettype none

module ngram_lexicon_counter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // data_byte[7:0], passage_index[23:8]
    input  wire logic          s_tuser,   // first_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [119:0]       m_tdata,   // gram_length[3:0], gram_value[67:4],
                                          // gram_count[83:68], gram_total[99:84],
                                          // report_index[115:100], zero pad
    output logic [1:0]         m_tuser,   // indexed[0], lexicon_full[1]
    output logic               m_tlast,   // last_of_byte
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [3:0]    cfg_wdata
);
    import ngl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLEAR,
        ST_NCHK,
        ST_SRCH,
        ST_CMP,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [3:0]  min_reg;
    logic [3:0]  max_reg;
    logic        upd_reg;

    logic [7:0]  byte_reg;
    logic [15:0] pidx_reg;
    logic        first_reg;
    logic [55:0] hist_reg;
    logic [2:0]  seen_reg;
    logic [GEN_W-1:0] gen_reg;
    logic [3:0]  n_reg;
    logic [FILL_W-1:0] s_reg;
    logic [STORE_AW-1:0] clr_reg;
    logic [FILL_W-1:0] fill_reg  [MAX_GRAM];
    logic [COUNT_BITS-1:0] total_reg [MAX_GRAM];

    logic        res_indexed_reg;
    logic        res_full_reg;
    logic [COUNT_BITS-1:0] res_count_reg;

    logic        mvalid_reg;
    logic [119:0] mdata_reg;
    logic [1:0]  muser_reg;
    logic        mlast_reg;

    logic [63:0] gram_rdata;
    logic [TALLY_W-1:0] tally_rdata;
    store_req_t  req;

    logic [63:0] window;
    logic [63:0] gram;
    logic [6:0]  shift;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [3:0]  avail;
    logic [3:0]  n_inc;
    logic [LEN_IW-1:0] len_idx;
    logic [FILL_W-1:0] fill_cur;
    logic [STORE_AW-1:0] base;
    logic        last_n;
    logic        out_free;
    logic [GEN_W-1:0] gen_inc;
    logic [COUNT_BITS-1:0] tot_cur;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [GEN_W-1:0] old_gen;

    assign window  = {byte_reg, hist_reg};
    assign shift   = 7'd64 - {n_reg, 3'b000};
    assign gram    = window >> shift;
    assign lo      = (min_reg == 4'd0) ? 4'd1 : min_reg;
    assign hi      = (max_reg > 4'(MAX_GRAM)) ? 4'(MAX_GRAM) : max_reg;
    assign avail   = {1'b0, seen_reg} + 4'd1;
    assign n_inc   = n_reg + 4'd1;
    assign len_idx = LEN_IW'(n_reg - 4'd1);
    assign fill_cur = fill_reg[len_idx];
    assign base    = STORE_AW'(32'(len_idx) * LEX_ENTRIES);
    assign last_n  = (n_inc > hi) || (n_inc > avail);
    assign out_free = !mvalid_reg || m_tready;
    assign gen_inc = gen_reg + 1'b1;
    assign tot_cur = total_reg[len_idx];
    assign old_gen = tally_rdata[TALLY_W-1:COUNT_BITS];
    assign old_cnt = tally_rdata[COUNT_BITS-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

    always_comb
    begin
        req = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                req.addr     = clr_reg;
                req.tally_we = 1'b1;
            end
            ST_SRCH:
            begin
                if (s_reg == fill_cur)
                begin
                    req.addr        = base + STORE_AW'(fill_cur);
                    req.gram_we     = upd_reg && (fill_cur != FILL_W'(LEX_ENTRIES));
                    req.tally_we    = req.gram_we;
                    req.gram_wdata  = gram;
                    req.tally_wdata = {gen_reg, COUNT_BITS'(1)};
                end
                else
                begin
                    req.addr  = base + STORE_AW'(s_reg);
                    req.rd_en = 1'b1;
                end
            end
            ST_CMP:
            begin
                req.addr     = base + STORE_AW'(s_reg);
                req.tally_we = (gram_rdata == gram);
                if (old_gen != gen_reg)
                begin
                    req.tally_wdata = {gen_reg, COUNT_BITS'(1)};
                end
                else
                begin
                    req.tally_wdata = {gen_reg,
                                       (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1};
                end
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    ngl_store u_store (
        .clk         (clk),
        .req         (req),
        .gram_rdata  (gram_rdata),
        .tally_rdata (tally_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            min_reg    <= 4'd1;
            max_reg    <= 4'd8;
            upd_reg    <= 1'b1;
            hist_reg   <= '0;
            seen_reg   <= '0;
            gen_reg    <= GEN_W'(1);
            n_reg      <= '0;
            s_reg      <= '0;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_GRAM; i++)
            begin
                fill_reg[i]  <= '0;
                total_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MIN_GRAM: min_reg <= cfg_wdata;
                    REG_MAX_GRAM: max_reg <= cfg_wdata;
                    REG_UPDATE:   upd_reg <= cfg_wdata[0];
                    default:      ;
                endcase
            end

            // A report loaded in the emit step replaces the one taken now.
            if (mvalid_reg && m_tready && !((state_reg == ST_EMIT) && out_free))
            begin
                mvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        byte_reg  <= s_tdata[7:0];
                        pidx_reg  <= s_tdata[23:8];
                        first_reg <= s_tuser;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    n_reg <= lo;
                    if (first_reg)
                    begin
                        hist_reg <= '0;
                        seen_reg <= '0;
                        for (int i = 0; i < MAX_GRAM; i++)
                        begin
                            total_reg[i] <= '0;
                        end
                        if (gen_inc == '0)
                        begin
                            // Old generation marks would alias the restarted count.
                            gen_reg   <= GEN_W'(1);
                            clr_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            gen_reg   <= gen_inc;
                            state_reg <= ST_NCHK;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_NCHK;
                    end
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == STORE_AW'(STORE_DEPTH - 1))
                    begin
                        state_reg <= ST_NCHK;
                    end
                end
                ST_NCHK:
                begin
                    s_reg <= '0;
                    if ((n_reg > hi) || (n_reg > avail))
                    begin
                        hist_reg  <= window[63:8];
                        seen_reg  <= (avail > 4'd7) ? 3'd7 : avail[2:0];
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH:
                begin
                    if (s_reg == fill_cur)
                    begin
                        res_indexed_reg <= req.gram_we;
                        res_full_reg    <= upd_reg && !req.gram_we;
                        res_count_reg   <= COUNT_BITS'(req.gram_we);
                        if (req.gram_we)
                        begin
                            fill_reg[len_idx] <= fill_cur + 1'b1;
                        end
                        if (tot_cur != COUNT_MAX)
                        begin
                            total_reg[len_idx] <= tot_cur + 1'b1;
                        end
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (req.tally_we)
                    begin
                        res_indexed_reg <= 1'b1;
                        res_full_reg    <= 1'b0;
                        res_count_reg   <= req.tally_wdata[COUNT_BITS-1:0];
                        if (tot_cur != COUNT_MAX)
                        begin
                            total_reg[len_idx] <= tot_cur + 1'b1;
                        end
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        s_reg     <= s_reg + 1'b1;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= {4'd0, pidx_reg, clip16(tot_cur),
                                       clip16(res_count_reg), gram, n_reg};
                        muser_reg  <= {res_full_reg, res_indexed_reg};
                        mlast_reg  <= last_n;
                        n_reg      <= n_inc;
                        if (last_n)
                        begin
                            hist_reg  <= window[63:8];
                            seen_reg  <= (avail > 4'd7) ? 3'd7 : avail[2:0];
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_NCHK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "ngram_lexicon_counter_assert.svh"

    `NGL_ASSERT_NOW(a_search_bound, state_reg == ST_SRCH, s_reg <= fill_cur)
    `NGL_ASSERT_NOW(a_clear_blocks, state_reg == ST_CLEAR, !s_tready)
    `NGL_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `NGL_ASSERT_NOW(a_gen_nonzero, state_reg != ST_PREP, gen_reg != '0)

endmodule

`default_nettype wire

>>> tb/sv/ngram_lexicon_counter_test.sv
// ----------------------------------------------------------------------------
// ngram_lexicon_counter_test
// Self-checking bench for the byte n-gram lexicon counter. Stream requests
// are driven with random gaps. Gram reports are compared field by field
// against an in-bench model of the per-length lexicons and passage counts.
// A directed table is walked first. Random passages follow under several
// gram ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module ngram_lexicon_counter_test;
    import ngl_pkg::*;

    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] val;
        logic        indexed;
        logic [15:0] cnt;
        logic [15:0] tot;
        logic        full;
        logic [15:0] idx;
        logic        last;
    } gram_report_t;

    typedef struct {
        int cnt;
        int gen;
    } lex_entry_t;

    // Directed row: optional register update, then one request and the
    // number of reports it must yield.
    typedef struct packed {
        bit          set_cfg;
        bit [3:0]    mn;
        bit [3:0]    mx;
        bit          up;
        bit [7:0]    data;
        bit          first;
        bit [15:0]   idx;
        bit [3:0]    nres;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [23:0]   s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;
    logic          cfg_we;
    logic [1:0]    cfg_addr;
    logic [3:0]    cfg_wdata;

    gram_report_t  pending_reports[$];
    lex_entry_t    lexicon[bit [67:0]];
    int            lex_fill[1:8];
    int            length_tot[1:8];
    logic [55:0]   history;
    int            seen_bytes;
    logic [15:0]   passage_gen;
    int            gram_min;
    int            gram_max;
    bit            insert_on;
    int            errors;
    int            requests_sent;
    int            reports_checked;
    int            full_reports;

    stim_row_t dir_rows[18] = '{
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h00, 1'b1, 16'h0000, 4'd1},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'hFF, 1'b0, 16'hFFFF, 4'd2},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h00, 1'b0, 16'h0001, 4'd3},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'hFF, 1'b0, 16'h8000, 4'd4},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h80, 1'b0, 16'h7FFF, 4'd5},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h01, 1'b0, 16'h5555, 4'd6},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h7F, 1'b0, 16'hAAAA, 4'd7},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'hFE, 1'b0, 16'h00FF, 4'd8},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h00, 1'b0, 16'hFF00, 4'd8},
        '{1'b0, 4'd0, 4'd0, 1'b0, 8'h00, 1'b1, 16'h1234, 4'd1},
        // Zero minimum acts as one, oversized maximum as eight; unseen
        // grams are reported but not inserted.
        '{1'b1, 4'd0, 4'd15, 1'b0, 8'h00, 1'b1, 16'h0002, 4'd1},
        '{1'b0, 4'd0, 4'd15, 1'b0, 8'hFF, 1'b0, 16'h0002, 4'd2},
        '{1'b0, 4'd0, 4'd15, 1'b0, 8'hAA, 1'b0, 16'h0002, 4'd3},
        '{1'b0, 4'd0, 4'd15, 1'b0, 8'h3C, 1'b0, 16'h0002, 4'd4},
        // Empty range: no reports at all.
        '{1'b1, 4'd5, 4'd3, 1'b1, 8'h11, 1'b1, 16'h0003, 4'd0},
        '{1'b0, 4'd5, 4'd3, 1'b1, 8'h22, 1'b0, 16'h0003, 4'd0},
        // Short passage: only length eight enabled.
        '{1'b1, 4'd8, 4'd8, 1'b1, 8'h5A, 1'b1, 16'h0004, 4'd0},
        '{1'b0, 4'd8, 4'd8, 1'b1, 8'hA5, 1'b0, 16'h0004, 4'd0}
    };

    ngram_lexicon_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 5_000_000);
        $display("ngram_lexicon_counter verification failed");
        $finish;
    end

    task automatic predict_reports(input logic [7:0] d, input logic first,
                                   input logic [15:0] pidx, output int made);
        logic [63:0]  window;
        logic [63:0]  g;
        bit [67:0]    key;
        int           lo;
        int           hi;
        int           avail;
        int           n;
        bit           hit;
        gram_report_t r;
        made = 0;
        if (first)
        begin
            passage_gen++;
            if (passage_gen == 16'd0)
            begin
                foreach (lexicon[k])
                    lexicon[k].gen = 0;
                passage_gen = 16'd1;
            end
            length_tot = '{default: 0};
            history    = '0;
            seen_bytes = 0;
        end
        window = {d, history};
        avail  = seen_bytes + 1;
        lo     = (gram_min == 0) ? 1 : gram_min;
        hi     = (gram_max > MAX_GRAM) ? MAX_GRAM : gram_max;
        for (n = lo; n <= hi && n <= avail; n++)
        begin
            g      = window >> (64 - 8 * n);
            key    = {n[3:0], g};
            r      = '0;
            hit    = lexicon.exists(key);
            if (!hit && insert_on)
            begin
                if (lex_fill[n] < LEX_ENTRIES)
                begin
                    lexicon[key] = '{0, 0};
                    lex_fill[n]++;
                    hit = 1'b1;
                end
                else
                    r.full = 1'b1;
            end
            if (hit)
            begin
                if (lexicon[key].gen != passage_gen)
                begin
                    lexicon[key].gen = passage_gen;
                    lexicon[key].cnt = 0;
                end
                if (lexicon[key].cnt < 65535)
                    lexicon[key].cnt++;
                r.indexed = 1'b1;
                r.cnt     = 16'(lexicon[key].cnt);
            end
            if (length_tot[n] < 65535)
                length_tot[n]++;
            r.len = 4'(n);
            r.val = g;
            r.tot = 16'(length_tot[n]);
            r.idx = pidx;
            pending_reports.push_back(r);
            made++;
        end
        if (made > 0)
            pending_reports[pending_reports.size() - 1].last = 1'b1;
        history    = window[63:8];
        seen_bytes = (avail > 7) ? 7 : avail;
    endtask

    // Drives one request, records its reports once accepted, then draws the
    // gap before the next one. Valid stays high across back-to-back requests.
    task automatic send_byte(input logic [7:0] d, input logic first,
                             input logic [15:0] pidx, output int made);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {pidx, d};
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        predict_reports(d, first, pidx, made);
        requests_sent++;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every report is in, then lets a request that yields none
    // finish before the registers change.
    task automatic drain_and_program(input int mn, input int mx, input bit up);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MIN_GRAM;
        cfg_wdata <= 4'(mn);
        @(posedge clk);
        cfg_addr  <= REG_MAX_GRAM;
        cfg_wdata <= 4'(mx);
        @(posedge clk);
        cfg_addr  <= REG_UPDATE;
        cfg_wdata <= {3'b000, up};
        @(posedge clk);
        cfg_we    <= 1'b0;
        gram_min  = mn;
        gram_max  = mx;
        insert_on = up;
    endtask

    // Mostly passages over a four-letter alphabet so grams recur; some
    // carry arbitrary bytes and some continue without a first-byte mark.
    task automatic random_passages(input int count);
        int          done;
        int          plen;
        int          mode;
        int          j;
        int          made;
        logic [15:0] pidx;
        logic [7:0]  d;
        logic        first;
        done = 0;
        while (done < count)
        begin
            plen = $urandom_range(1, 12);
            mode = $urandom_range(0, 9);
            pidx = 16'($urandom());
            for (j = 0; j < plen && done < count; j++)
            begin
                d = (mode < 7) ? 8'h41 + 8'($urandom_range(0, 3))
                               : 8'($urandom_range(0, 255));
                first = (mode == 9) ? 1'b0 : (j == 0);
                if (mode == 8 && $urandom_range(0, 5) == 0)
                    first = 1'b1;
                send_byte(d, first, pidx, made);
                done++;
            end
        end
    endtask

    // Result side: random stalls, then compare each report with the oldest
    // expectation.
    initial
    begin
        int           w;
        gram_report_t got;
        gram_report_t want;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.len     = m_tdata[3:0];
            got.val     = m_tdata[67:4];
            got.cnt     = m_tdata[83:68];
            got.tot     = m_tdata[99:84];
            got.idx     = m_tdata[115:100];
            got.indexed = m_tuser[0];
            got.full    = m_tuser[1];
            got.last    = m_tlast;
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected gram report, length %0d", got.len);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.full)
                    full_reports++;
                if (got.len !== want.len)
                begin
                    $error("gram_length: expected %0d, got %0d", want.len, got.len);
                    errors++;
                end
                if (got.val !== want.val)
                begin
                    $error("gram_value: expected %h, got %h", want.val, got.val);
                    errors++;
                end
                if (got.indexed !== want.indexed)
                begin
                    $error("indexed: expected %0d, got %0d", want.indexed, got.indexed);
                    errors++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $error("gram_count: expected %0d, got %0d", want.cnt, got.cnt);
                    errors++;
                end
                if (got.tot !== want.tot)
                begin
                    $error("gram_total: expected %0d, got %0d", want.tot, got.tot);
                    errors++;
                end
                if (got.full !== want.full)
                begin
                    $error("lexicon_full: expected %0d, got %0d", want.full, got.full);
                    errors++;
                end
                if (got.idx !== want.idx)
                begin
                    $error("report_index: expected %h, got %h", want.idx, got.idx);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last_of_byte: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int made;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_MIN_GRAM;
        cfg_wdata   = '0;
        errors      = 0;
        requests_sent   = 0;
        reports_checked = 0;
        full_reports    = 0;
        gram_min    = 1;
        gram_max    = 8;
        insert_on   = 1'b1;
        history     = '0;
        seen_bytes  = 0;
        passage_gen = 16'd1;
        lex_fill    = '{default: 0};
        length_tot  = '{default: 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_cfg)
                drain_and_program(dir_rows[i].mn, dir_rows[i].mx, dir_rows[i].up);
            send_byte(dir_rows[i].data, dir_rows[i].first, dir_rows[i].idx, made);
            if (made != dir_rows[i].nres)
            begin
                $error("reports per request: expected %0d, got %0d",
                       dir_rows[i].nres, made);
                errors++;
            end
        end

        drain_and_program(3, 6, 1'b1);
        random_passages(20);
        drain_and_program(8, 8, 1'b1);
        random_passages(20);
        drain_and_program(1, 1, 1'b0);
        random_passages(15);
        drain_and_program($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom()));
        random_passages(15);
        drain_and_program(2, 5, 1'b0);
        random_passages(15);
        drain_and_program(1, 8, 1'b1);
        random_passages(30);

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Checked %0d gram reports from %0d byte requests over several gram ranges,",
                 reports_checked, requests_sent);
        $display("with %0d reports flagging a full lexicon.", full_reports);
        if (errors == 0)
            $display("ngram_lexicon_counter verification clean");
        else
            $display("ngram_lexicon_counter verification failed");
        $finish;
    end

endmodule

`default_nettype wire
